[hw/rtl/ple_pkg.sv]
// Package for the positional list engine: field widths, command and status
// codes, and the command/status structs between controller and datapath.
// Depends on nothing.
`default_nettype none

package ple_pkg;

   localparam int CMD_W = 2;
   localparam int POS_W = 6;
   localparam int VAL_W = 32;
   localparam int ST_W  = 2;
   localparam int LEN_W = 6;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

   localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
   localparam logic [ST_W-1:0] ST_BEYOND = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the request and set up the index
      logic step_up;    // insert shift: read idx-1, write it to idx next cycle
      logic step_dn;    // delete shift: read idx+1, write it to idx next cycle
      logic step_scan;  // find: read idx, compare next cycle
      logic ins_wr;     // write the new value at its position, count up
      logic del_dec;    // count down after a delete
      logic out_load;   // load the result register
   } ple_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;       // list holds CAPACITY entries
      logic beyond;     // requested position is at or past the end
      logic up_more;    // insert shift has entries left to move
      logic dn_more;    // delete shift has entries left to move
      logic scan_more;  // find has entries left to read
      logic wr_pend;    // a shift write is due this cycle
      logic cmp_pend;   // a find compare is due this cycle
   } ple_stat_type;

endpackage

`default_nettype wire

[hw/rtl/ple_ctrl.sv]
// Controller state machine of the positional list engine.
// Depends on ple_pkg for the command/status structs and command codes.
`default_nettype none

module ple_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [ple_pkg::CMD_W-1:0] req_cmd,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire ple_pkg::ple_stat_type     st,
   output ple_pkg::ple_cmd_type           cmd
);
   import ple_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UP   = 3'd1;
   localparam logic [2:0] S_DN   = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_cmd)
                  CMD_INSERT: state_in = st.full ? S_FIN : S_UP;
                  CMD_DELETE: state_in = st.beyond ? S_FIN : S_DN;
                  CMD_FIND:   state_in = S_SCAN;
                  default:    state_in = S_FIN;
               endcase
            end
         end
         S_UP: begin
            cmd.step_up = st.up_more;
            if (!st.up_more && !st.wr_pend) begin
               cmd.ins_wr = 1'b1;
               state_in   = S_FIN;
            end
         end
         S_DN: begin
            cmd.step_dn = st.dn_more;
            if (!st.dn_more && !st.wr_pend) begin
               cmd.del_dec = 1'b1;
               state_in    = S_FIN;
            end
         end
         S_SCAN: begin
            cmd.step_scan = st.scan_more;
            if (!st.scan_more && !st.cmp_pend) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The final insert write must never collide with a pending shift write.
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins_wr && st.wr_pend))
      else $error("insert write collides with shift write");

   // At most one memory operation is commanded in a cycle.
   a_one_mem_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.step_up, cmd.step_dn, cmd.step_scan, cmd.ins_wr}))
      else $error("more than one memory operation commanded");

   // Once a request is taken, no other is taken in the following cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one still in progress");

endmodule

`default_nettype wire

[hw/rtl/ple_dpath.sv]
// Datapath of the positional list engine: list memory, count, shift/scan
// index, compare logic and the result register.
// Depends on ple_pkg for widths, codes and the command/status structs.
`default_nettype none

module ple_dpath #(
   parameter int CAPACITY = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ple_pkg::ple_cmd_type             cmd,
   output ple_pkg::ple_stat_type                 st,
   input  wire logic [ple_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [ple_pkg::POS_W-1:0]        req_position,
   input  wire logic signed [ple_pkg::VAL_W-1:0] req_value,
   output logic                                  rsp_found,
   output logic [ple_pkg::ST_W-1:0]              rsp_status,
   output logic [ple_pkg::LEN_W-1:0]             rsp_length
);
   import ple_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int WW = (CW > POS_W) ? CW : POS_W;

   logic [VAL_W-1:0] mem [CAPACITY];

   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    pos_ff, pos_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [ST_W-1:0]  status_ff, status_in;
   logic             found_ff, found_in;
   logic             wr_pend_ff, wr_pend_in;
   logic             cmp_pend_ff, cmp_pend_in;
   logic [AW-1:0]    dest_ff, dest_in;
   logic [VAL_W-1:0] rdata_ff;

   logic             rsp_found_ff;
   logic [ST_W-1:0]  rsp_status_ff;
   logic [LEN_W-1:0] rsp_length_ff;

   logic [WW-1:0]    pos_ext, cnt_ext;
   logic [CW-1:0]    pos_clamp;
   logic [CW-1:0]    idx_dec, idx_inc;
   logic [CW:0]      idx_inc_wide;
   logic             mem_re, mem_we;
   logic [AW-1:0]    raddr, waddr;
   logic [VAL_W-1:0] wdata;

   assign pos_ext      = WW'(req_position);
   assign cnt_ext      = WW'(cnt_ff);
   assign pos_clamp    = (pos_ext > cnt_ext) ? cnt_ff : pos_ext[CW-1:0];
   assign idx_dec      = idx_ff - CW'(1);
   assign idx_inc      = idx_ff + CW'(1);
   assign idx_inc_wide = {1'b0, idx_ff} + (CW+1)'(1);

   always_comb begin
      st           = '0;
      st.full      = (cnt_ff == CW'(CAPACITY));
      st.beyond    = (pos_ext >= cnt_ext);
      st.up_more   = (idx_ff > pos_ff);
      st.dn_more   = (idx_inc_wide < {1'b0, cnt_ff});
      st.scan_more = (idx_ff < cnt_ff) && !found_ff;
      st.wr_pend   = wr_pend_ff;
      st.cmp_pend  = cmp_pend_ff;
   end

   // Memory port selection.
   assign mem_re = cmd.step_up || cmd.step_dn || cmd.step_scan;
   assign mem_we = wr_pend_ff || cmd.ins_wr;
   assign waddr  = cmd.ins_wr ? pos_ff[AW-1:0] : dest_ff;
   assign wdata  = cmd.ins_wr ? val_ff : rdata_ff;

   always_comb begin
      priority if (cmd.step_up) begin
         raddr = idx_dec[AW-1:0];
      end else if (cmd.step_dn) begin
         raddr = idx_inc[AW-1:0];
      end else begin
         raddr = idx_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_comb begin
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      dest_in     = dest_ff;
      wr_pend_in  = cmd.step_up || cmd.step_dn;
      cmp_pend_in = cmd.step_scan;

      if (cmd.load) begin
         pos_in   = pos_clamp;
         val_in   = req_value;
         found_in = 1'b0;
         unique case (req_cmd)
            CMD_INSERT: begin
               idx_in    = cnt_ff;
               status_in = st.full ? ST_FULL : ST_DONE;
            end
            CMD_DELETE: begin
               idx_in    = pos_clamp;
               status_in = st.beyond ? ST_BEYOND : ST_DONE;
            end
            default: begin
               idx_in    = '0;
               status_in = ST_DONE;
            end
         endcase
      end

      if (cmd.step_up) begin
         dest_in = idx_ff[AW-1:0];
         idx_in  = idx_dec;
      end
      if (cmd.step_dn) begin
         dest_in = idx_ff[AW-1:0];
         idx_in  = idx_inc;
      end
      if (cmd.step_scan) begin
         idx_in = idx_inc;
      end

      if (cmp_pend_ff && (rdata_ff == val_ff)) begin
         found_in = 1'b1;
      end

      if (cmd.ins_wr) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd.del_dec) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         wr_pend_ff  <= 1'b0;
         cmp_pend_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         wr_pend_ff  <= wr_pend_in;
         cmp_pend_ff <= cmp_pend_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      dest_ff   <= dest_in;
      if (cmd.out_load) begin
         rsp_found_ff  <= found_ff;
         rsp_status_ff <= status_ff;
         rsp_length_ff <= cnt_ext[LEN_W-1:0];
      end
   end

   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_length = rsp_length_ff;

   // The list never holds more entries than its capacity.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("list count exceeds capacity");

   // An insert grows the list by exactly one entry.
   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_wr |=> (cnt_ff == CW'($past(cnt_ff) + CW'(1))))
      else $error("insert did not grow the list by one");

   // A shift write only follows a shift read issued the cycle before.
   a_wr_follows_rd: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> $past(cmd.step_up || cmd.step_dn))
      else $error("shift write without a preceding read");

endmodule

`default_nettype wire

[hw/rtl/positional_list_engine_unit.sv]
// Top level of the positional list engine: an ordered list of signed values.
// Depends on ple_pkg, ple_ctrl and ple_dpath.
//
// Commands arrive on the req_ channel and each accepted transaction yields exactly
// one rsp_ transaction. Insert puts a value at a position (past the end appends),
// delete removes the entry at a position, find searches for a value.
//
// One command is worked on at a time; req_ready is high only while the controller
// is idle. Shifts and searches move one entry per cycle through the list memory's
// registered read port. After a command is accepted, an insert at p inside the list
// shifts the (length - p) entries from p on up, a delete at p below the last entry
// shifts the entries above p down, and a find reads m entries (all of them on a miss,
// at most one past a hit); an append, a delete of the last entry or a find on an
// empty list moves no entry, and a refused insert, an ignored delete or a no-operation
// goes straight to the finish state, where the result register is loaded. The next
// transaction is taken once the controller is idle again, so a find that misses in a
// full list is the slowest transaction.
//
// While the receiver holds rsp_ready low, the block still accepts and works on
// the next command, then waits until the output register is free. A synchronous
// reset empties the list and drops rsp_valid; the memory itself is not cleared,
// since only entries below the length are ever read.
`default_nettype none

module positional_list_engine_unit #(
   parameter int CAPACITY = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [ple_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [ple_pkg::POS_W-1:0]        req_position,
   input  wire logic signed [ple_pkg::VAL_W-1:0] req_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_found,
   output logic [ple_pkg::ST_W-1:0]              rsp_status,
   output logic [ple_pkg::LEN_W-1:0]             rsp_length
);
   import ple_pkg::*;

   // Commands from the controller and status from the datapath.
   ple_cmd_type  cmd;
   ple_stat_type st;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // The datapath holds the list, its length and the result register.
   ple_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_found    (rsp_found),
      .rsp_status   (rsp_status),
      .rsp_length   (rsp_length)
   );

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for positional_list_engine_unit, the ordered list of signed values.
// Depends on ple_pkg and the positional_list_engine_unit RTL. Reads no files.

module tb_top;
   import ple_pkg::*;

   localparam int LIST_CAPACITY = 32;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int QUIET_TAIL    = 150;      // the last transactions run with no idling
   localparam int DRAIN_CYCLES  = 40;       // longer than the slowest command
   localparam int CYCLE_LIMIT   = 500000;

   // One command transaction as it goes onto the req_ channel.
   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } list_cmd_type;

   // One result transaction as it comes off the rsp_ channel.
   typedef struct packed {
      logic              found;
      logic [ST_W-1:0]   status;
      logic [LEN_W-1:0]  length;
   } list_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [CMD_W-1:0]        req_cmd = CMD_NOP;
   logic [POS_W-1:0]        req_position = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_found;
   logic [ST_W-1:0]         rsp_status;
   logic [LEN_W-1:0]        rsp_length;

   // Commands waiting for the driver, results waiting for the checker.
   list_cmd_type            pending_cmd_q[$];
   list_rsp_type            expected_rsp_q[$];

   // The predictor's own copy of the list contents, front of the list first.
   logic signed [VAL_W-1:0] list_contents_q[$];

   // Values that are reused often, so that finds hit stored entries.
   logic signed [VAL_W-1:0] value_pool [16] = '{
      32'sh0000_0000, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh7FFF_FFFF,
      32'sh8000_0000, 32'sh0000_0005, 32'sh0000_002A, 32'sh0000_0064,
      32'shFFFF_FF9C, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0007,
      32'sh0000_03E8, 32'shFFFF_FFF9, 32'sh0000_00FF, 32'sh0000_0100};

   int    plan_count;     // list length as the stimulus generator expects it
   int    total_items;
   int    sent_cnt;       // command transactions placed on the req_ channel
   int    accepted_cnt;   // command transactions accepted by the block
   int    error_cnt;
   int    cycle_cnt;
   int    gap_left;
   int    stall_left;
   bit    req_fired;      // a command transaction was accepted at the last rising edge

   positional_list_engine_unit #(
      .CAPACITY(LIST_CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_found(rsp_found),
      .rsp_status(rsp_status),
      .rsp_length(rsp_length)
   );

   always #10 clock = ~clock;

   // Applies one command to the predicted list and returns the result it should produce.
   // Insert at or past the end appends, insert into a full list is refused, delete at or
   // past the end is ignored, and find only reports a hit. The unused code does nothing.
   function automatic list_rsp_type apply_list_command(input logic [CMD_W-1:0] cmd,
                                                       input logic [POS_W-1:0] position,
                                                       input logic signed [VAL_W-1:0] value);
      list_rsp_type result;
      int           slot;
      result = '0;
      result.status = ST_DONE;
      case (cmd)
         CMD_INSERT: begin
            if (list_contents_q.size() >= LIST_CAPACITY) begin
               result.status = ST_FULL;
            end else begin
               slot = (position > list_contents_q.size()) ? list_contents_q.size() : position;
               list_contents_q.insert(slot, value);
            end
         end
         CMD_DELETE: begin
            if (position >= list_contents_q.size()) begin
               result.status = ST_BEYOND;
            end else begin
               list_contents_q.delete(position);
            end
         end
         CMD_FIND: begin
            foreach (list_contents_q[i]) begin
               if (list_contents_q[i] == value) begin
                  result.found = 1'b1;
               end
            end
         end
         default: ;
      endcase
      // The length field wraps when the list is longer than it can show.
      result.length = LEN_W'(list_contents_q.size());
      return result;
   endfunction

   // Queues one command for the driver and tracks the length the generator expects.
   task automatic queue_list_command(input logic [CMD_W-1:0] cmd, input int position,
                                     input logic signed [VAL_W-1:0] value);
      list_cmd_type item;
      item.cmd      = cmd;
      item.position = POS_W'(position);
      item.value    = value;
      pending_cmd_q.push_back(item);
      if (cmd == CMD_INSERT && plan_count < LIST_CAPACITY) begin
         plan_count++;
      end else if (cmd == CMD_DELETE && item.position < plan_count) begin
         plan_count--;
      end
   endtask

   // Idling runs in windows, with quiet stretches between them and none near the end.
   function automatic bit idling_allowed();
      return (sent_cnt + QUIET_TAIL < total_items) && (((sent_cnt / 120) % 4) != 3);
   endfunction

   task automatic report_mismatch(input string field_name, input int expected_val,
                                  input int actual_val);
      $display("%0t ns: rsp_%s mismatch, expected %0d, actual %0d",
               $time, field_name, expected_val, actual_val);
      error_cnt++;
   endtask

   // Stimulus: a short directed part, then random commands, then the end of the run.
   initial begin : stimulus
      int                      n;
      int                      roll;
      int                      position;
      bit                      growing;
      logic [CMD_W-1:0]        cmd;
      logic signed [VAL_W-1:0] value;

      plan_count = 0;

      // Empty list: find misses, deletes anywhere are ignored, the unused code does nothing.
      queue_list_command(CMD_FIND,   0,  32'sh0000_0000);
      queue_list_command(CMD_DELETE, 0,  32'sh0000_0000);
      queue_list_command(CMD_DELETE, 63, 32'shFFFF_FFFF);
      queue_list_command(CMD_NOP,    63, 32'shFFFF_FFFF);
      // Build a list with the extreme values, appending from far past the end,
      // inserting at the front and in the middle.
      queue_list_command(CMD_INSERT, 63, 32'sh7FFF_FFFF);
      queue_list_command(CMD_INSERT, 0,  32'sh8000_0000);
      queue_list_command(CMD_INSERT, 1,  32'sh0000_0000);
      queue_list_command(CMD_INSERT, 32, 32'shFFFF_FFFF);
      queue_list_command(CMD_INSERT, 2,  32'sh0000_002A);
      // Finds that hit the front and the back, and one that misses.
      queue_list_command(CMD_FIND,   0,  32'sh8000_0000);
      queue_list_command(CMD_FIND,   0,  32'shFFFF_FFFF);
      queue_list_command(CMD_FIND,   0,  32'sh0000_0007);
      // Delete just past the end, then the last, the first and a middle entry.
      queue_list_command(CMD_DELETE, 5,  32'sh0000_0000);
      queue_list_command(CMD_DELETE, 4,  32'sh0000_0000);
      queue_list_command(CMD_DELETE, 0,  32'sh0000_0000);
      queue_list_command(CMD_DELETE, 1,  32'sh0000_0000);
      // Removed values must no longer be found.
      queue_list_command(CMD_FIND,   0,  32'shFFFF_FFFF);
      queue_list_command(CMD_FIND,   0,  32'sh0000_002A);
      queue_list_command(CMD_NOP,    0,  32'sh0000_0000);
      queue_list_command(CMD_INSERT, 1,  32'sh5555_5555);

      // Random part: the list grows until it is full and refuses a few inserts, then
      // shrinks until it is empty and ignores a few deletes, with occasional changes of
      // direction in between. Positions are mostly inside the list.
      growing = 1'b1;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         if (growing) begin
            cmd = (roll < 70) ? CMD_INSERT : (roll < 80) ? CMD_DELETE :
                  (roll < 97) ? CMD_FIND : CMD_NOP;
         end else begin
            cmd = (roll < 20) ? CMD_INSERT : (roll < 75) ? CMD_DELETE :
                  (roll < 97) ? CMD_FIND : CMD_NOP;
         end
         if (cmd == CMD_INSERT && $urandom_range(0, 9) != 0) begin
            position = $urandom_range(0, plan_count);
         end else if (cmd == CMD_DELETE && plan_count > 0 && $urandom_range(0, 9) != 0) begin
            position = $urandom_range(0, plan_count - 1);
         end else begin
            position = $urandom_range(0, 63);
         end
         if ($urandom_range(0, 1) == 0) begin
            value = value_pool[$urandom_range(0, 15)];
         end else begin
            value = $urandom();
         end
         queue_list_command(cmd, position, value);
         if (growing && plan_count == LIST_CAPACITY && $urandom_range(0, 3) == 0) begin
            growing = 1'b0;
         end else if (!growing && plan_count == 0 && $urandom_range(0, 3) == 0) begin
            growing = 1'b1;
         end else if ($urandom_range(0, 79) == 0) begin
            growing = !growing;
         end
      end
      total_items = pending_cmd_q.size();

      // Synchronous reset, released at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait until every command transaction is accepted and answered, then give the
      // block time to show any result that it should not produce.
      while (accepted_cnt < total_items || expected_rsp_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_cnt == 0) begin
         $display("positional_list_engine_unit test passed");
      end else begin
         $display("positional_list_engine_unit test failed");
      end
      $finish;
   end

   // Request driver. It changes the req_ inputs at the falling edge only, holds a command
   // until its transaction is accepted, and inserts idle bursts.
   always @(negedge clock) begin : req_driver
      list_cmd_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // The current command is still waiting for req_ready.
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_cmd_q.size() != 0) begin
         if (idling_allowed() && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else begin
            item = pending_cmd_q.pop_front();
            req_valid    <= 1'b1;
            req_cmd      <= item.cmd;
            req_position <= item.position;
            req_value    <= item.value;
            sent_cnt++;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result receiver. It stalls rsp_ready in bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor. At each rising edge, an accepted command transaction updates the predicted
   // list and queues its expected result; an accepted result transaction is checked field
   // by field against the oldest expected result.
   always @(posedge clock) begin : monitor
      list_rsp_type expected_rsp;
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         req_fired = req_valid && req_ready;
         if (req_fired) begin
            expected_rsp_q.push_back(apply_list_command(req_cmd, req_position, req_value));
            accepted_cnt++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t ns: result with no command outstanding, expected none, %s",
                        $time, $sformatf("actual %0b %0d %0d",
                                         rsp_found, rsp_status, rsp_length));
               error_cnt++;
            end else begin
               expected_rsp = expected_rsp_q.pop_front();
               if (rsp_found !== expected_rsp.found) begin
                  report_mismatch("found", expected_rsp.found, rsp_found);
               end
               if (rsp_status !== expected_rsp.status) begin
                  report_mismatch("status", expected_rsp.status, rsp_status);
               end
               if (rsp_length !== expected_rsp.length) begin
                  report_mismatch("length", expected_rsp.length, rsp_length);
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("positional_list_engine_unit test failed");
         $finish;
      end
   end

endmodule
